// ===== rtl/shk_pkg.sv =====
// Shared types, constants and lookup functions for the shortcut key remapper.
`timescale 1ns / 1ps
`default_nettype none

package shk_pkg;

    // Default depth of the held-key list
    localparam int LIST_DEPTH = 32;

    // Field widths
    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 32;
    localparam int TAG_W   = 6;

    // Event type for key events
    localparam logic [TYPE_W-1:0] TYPE_KEY = 16'd1;

    // Event value codes, low two bits once the upper bits are known zero
    localparam logic [1:0] VAL_RELEASE = 2'd0;
    localparam logic [1:0] VAL_PRESS   = 2'd1;
    localparam logic [1:0] VAL_REPEAT  = 2'd2;

    // Shortcut modifier key codes
    localparam logic [CODE_W-1:0] KEY_LCTRL = 16'd29;
    localparam logic [CODE_W-1:0] KEY_RCTRL = 16'd97;
    localparam logic [CODE_W-1:0] KEY_LALT  = 16'd56;
    localparam logic [CODE_W-1:0] KEY_WIN   = 16'd125;

    // Layout modifier key codes
    localparam logic [CODE_W-1:0] KEY_CAPS  = 16'd58;
    localparam logic [CODE_W-1:0] KEY_K43   = 16'd43;
    localparam logic [CODE_W-1:0] KEY_K86   = 16'd86;
    localparam logic [CODE_W-1:0] KEY_ALTGR = 16'd100;

    typedef struct packed {
        logic [TYPE_W-1:0]         event_type;
        logic [CODE_W-1:0]         key_code;
        logic signed [VALUE_W-1:0] event_value;
    } t_in;

    typedef struct packed {
        logic [TYPE_W-1:0]         out_type;
        logic [CODE_W-1:0]         out_code;
        logic signed [VALUE_W-1:0] out_value;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    // Fixed layout table: returns the code unchanged when it has no entry
    function automatic logic [CODE_W-1:0] layout_map(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] res;
        res = code;
        unique case (code)
            16'd12: res = 16'd25;
            16'd13: res = 16'd13;
            16'd16: res = 16'd45;
            16'd17: res = 16'd51;
            16'd18: res = 16'd32;
            16'd19: res = 16'd37;
            16'd20: res = 16'd36;
            16'd21: res = 16'd26;
            16'd22: res = 16'd34;
            16'd23: res = 16'd33;
            16'd24: res = 16'd18;
            16'd25: res = 16'd50;
            16'd26: res = 16'd47;
            16'd27: res = 16'd27;
            16'd30: res = 16'd31;
            16'd31: res = 16'd39;
            16'd32: res = 16'd35;
            16'd33: res = 16'd40;
            16'd34: res = 16'd22;
            16'd35: res = 16'd30;
            16'd36: res = 16'd53;
            16'd37: res = 16'd16;
            16'd38: res = 16'd24;
            16'd39: res = 16'd48;
            16'd40: res = 16'd46;
            16'd44: res = 16'd20;
            16'd45: res = 16'd44;
            16'd46: res = 16'd23;
            16'd47: res = 16'd21;
            16'd48: res = 16'd49;
            16'd49: res = 16'd38;
            16'd50: res = 16'd52;
            16'd51: res = 16'd19;
            16'd52: res = 16'd17;
            16'd53: res = 16'd12;
            default: res = code;
        endcase
        return res;
    endfunction

    function automatic logic [3:0] shortcut_bit(input logic [CODE_W-1:0] code);
        logic [3:0] res;
        res = 4'b0000;
        unique case (code)
            KEY_LCTRL: res = 4'b0001;
            KEY_RCTRL: res = 4'b0010;
            KEY_LALT:  res = 4'b0100;
            KEY_WIN:   res = 4'b1000;
            default:   res = 4'b0000;
        endcase
        return res;
    endfunction

    function automatic logic [3:0] layout_mod_bit(input logic [CODE_W-1:0] code);
        logic [3:0] res;
        res = 4'b0000;
        unique case (code)
            KEY_CAPS:  res = 4'b0001;
            KEY_K43:   res = 4'b0010;
            KEY_K86:   res = 4'b0100;
            KEY_ALTGR: res = 4'b1000;
            default:   res = 4'b0000;
        endcase
        return res;
    endfunction

    // Press sets the bit, release clears it, repeat leaves the mask alone
    function automatic logic [3:0] update_mask(input logic [3:0] mask,
                                               input logic [3:0] bits,
                                               input logic [1:0] val);
        logic [3:0] res;
        res = mask;
        unique case (val)
            VAL_PRESS:   res = mask | bits;
            VAL_RELEASE: res = mask & ~bits;
            default:     res = mask;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/shk_list_ram.sv =====
// Held-key list storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module shk_list_ram #(
    parameter int DEPTH  = shk_pkg::LIST_DEPTH,
    parameter int ADDR_W = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [ADDR_W-1:0]         i_waddr,
    input  wire logic [shk_pkg::TAG_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [ADDR_W-1:0]         i_raddr,
    output logic      [shk_pkg::TAG_W-1:0] o_rdata
);

    logic [shk_pkg::TAG_W-1:0] r_mem [DEPTH];
    logic [shk_pkg::TAG_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/shk_engine.sv =====
// Event engine: modifier masks, held-key append and serial release scan.
`timescale 1ns / 1ps
`default_nettype none

module shk_engine #(
    parameter int LIST_DEPTH = shk_pkg::LIST_DEPTH,
    parameter int ADDR_W     = 5,
    parameter int CNT_W      = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // incoming items
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire shk_pkg::t_in              i_in_data,
    // finished results toward the output register
    output logic                           o_res_valid,
    input  wire logic                      i_res_ready,
    output shk_pkg::t_out                  o_res_data,
    // list memory
    output logic                           o_we,
    output logic      [ADDR_W-1:0]         o_waddr,
    output logic      [shk_pkg::TAG_W-1:0] o_wdata,
    output logic                           o_re,
    output logic      [ADDR_W-1:0]         o_raddr,
    input  wire logic [shk_pkg::TAG_W-1:0] i_rdata
);

    shk_pkg::t_state r_state, n_state;
    logic [3:0]      r_sc, n_sc;
    logic [3:0]      r_lm, n_lm;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic            r_cmp_v, n_cmp_v;
    logic [ADDR_W-1:0] r_cmp_idx, n_cmp_idx;
    logic            r_found, n_found;
    logic [CNT_W-1:0] r_last, n_last;
    logic [shk_pkg::TAG_W-1:0] r_tag, n_tag;
    logic [shk_pkg::CODE_W-1:0] r_mapped, n_mapped;
    logic [shk_pkg::CODE_W-1:0] r_result, n_result;
    shk_pkg::t_in    r_item, n_item;

    // Decode of the item at the input
    logic                       in_is_key;
    logic [1:0]                 in_val;
    logic [3:0]                 in_sc;
    logic [3:0]                 in_lm;
    logic [shk_pkg::CODE_W-1:0] in_mapped;
    logic                       in_remap;
    logic [shk_pkg::TAG_W-1:0]  in_tag;

    always_comb begin
        in_is_key = (i_in_data.event_type == shk_pkg::TYPE_KEY) &&
                    (i_in_data.event_value[shk_pkg::VALUE_W-1:2] == '0);
        in_val    = i_in_data.event_value[1:0];
        in_sc     = shk_pkg::update_mask(r_sc, shk_pkg::shortcut_bit(i_in_data.key_code),
                                         in_val);
        in_lm     = shk_pkg::update_mask(r_lm, shk_pkg::layout_mod_bit(i_in_data.key_code),
                                         in_val);
        in_mapped = shk_pkg::layout_map(i_in_data.key_code);
        in_remap  = in_is_key && (in_mapped != i_in_data.key_code) &&
                    ((in_sc != 4'b0000) || (r_count != '0)) && (in_lm == 4'b0000);
        in_tag    = i_in_data.key_code[shk_pkg::TAG_W-1:0] + shk_pkg::TAG_W'(1);
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shk_pkg::S_IDLE;
            r_sc    <= 4'b0000;
            r_lm    <= 4'b0000;
            r_count <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sc    <= n_sc;
            r_lm    <= n_lm;
            r_count <= n_count;
            r_cmp_v <= n_cmp_v;
        end
    end

    // Scan and payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_last    <= n_last;
        r_tag     <= n_tag;
        r_mapped  <= n_mapped;
        r_result  <= n_result;
        r_item    <= n_item;
    end

    // Next state and memory control
    always_comb begin
        n_state   = r_state;
        n_sc      = r_sc;
        n_lm      = r_lm;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_v   = r_cmp_v;
        n_cmp_idx = r_cmp_idx;
        n_found   = r_found;
        n_last    = r_last;
        n_tag     = r_tag;
        n_mapped  = r_mapped;
        n_result  = r_result;
        n_item    = r_item;
        o_we      = 1'b0;
        o_waddr   = r_count[ADDR_W-1:0];
        o_wdata   = in_tag;
        o_re      = 1'b0;
        o_raddr   = r_idx[ADDR_W-1:0];

        unique case (r_state)
            shk_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in_data;
                    n_result = i_in_data.key_code;
                    n_state  = shk_pkg::S_EMIT;
                    if (in_is_key) begin
                        n_sc = in_sc;
                        n_lm = in_lm;
                    end
                    if (in_remap && (in_val == shk_pkg::VAL_PRESS)) begin
                        // append unless the list is full
                        if (r_count < CNT_W'(LIST_DEPTH)) begin
                            o_we     = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_result = in_mapped;
                        end
                    end else if (in_remap && (in_val == shk_pkg::VAL_RELEASE)) begin
                        n_tag    = in_tag;
                        n_mapped = in_mapped;
                        n_idx    = '0;
                        n_found  = 1'b0;
                        n_last   = '0;
                        n_cmp_v  = 1'b0;
                        n_state  = shk_pkg::S_SCAN;
                    end
                end
            end

            shk_pkg::S_SCAN: begin
                // read stage: one entry per cycle
                n_cmp_v = 1'b0;
                if (r_idx < r_count) begin
                    o_re      = 1'b1;
                    n_idx     = r_idx + CNT_W'(1);
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_idx[ADDR_W-1:0];
                end
                // compare stage: clear matches, track the last surviving entry
                if (r_cmp_v) begin
                    if (i_rdata == r_tag) begin
                        o_we    = 1'b1;
                        o_waddr = r_cmp_idx;
                        o_wdata = '0;
                        n_found = 1'b1;
                    end else if (i_rdata != '0) begin
                        n_last = CNT_W'(r_cmp_idx) + CNT_W'(1);
                    end
                end
                // done once every entry went through compare; trim the tail
                if (!r_cmp_v && (r_idx >= r_count)) begin
                    n_count  = r_last;
                    n_result = r_found ? r_mapped : r_item.key_code;
                    n_state  = shk_pkg::S_EMIT;
                end
            end

            shk_pkg::S_EMIT: begin
                if (i_res_ready) begin
                    n_state = shk_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = shk_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready           = (r_state == shk_pkg::S_IDLE);
    assign o_res_valid          = (r_state == shk_pkg::S_EMIT);
    assign o_res_data.out_type  = r_item.event_type;
    assign o_res_data.out_code  = r_result;
    assign o_res_data.out_value = r_item.event_value;

endmodule

`default_nettype wire

// ===== rtl/shortcut_key_remapper_core.sv =====
// Top level of the shortcut key remapper: engine, list memory, output register.
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+------------------------------
//   input    | i_in_valid   | o_in_ready   | i_in_data  (shk_pkg::t_in)
//   output   | o_out_valid  | i_out_ready  | o_out_data (shk_pkg::t_out)
//
// One item at a time. Most items go from accept to the emit state and on into the output
// register once it can take them; the input reopens only after the result is taken, so
// a new item is not accepted before the last one has left the engine. A key release on
// the remap path first goes through a serial scan of the held-key list through the
// memory's single read port.
// A new item is accepted while the previous result waits in the output register.
// Synchronous active-low reset clears masks and fill count; list memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module shortcut_key_remapper_core #(
    parameter int LIST_DEPTH = shk_pkg::LIST_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire shk_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output shk_pkg::t_out      o_out_data
);

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

    logic                      res_valid;
    logic                      res_ready;
    shk_pkg::t_out             res_data;
    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [shk_pkg::TAG_W-1:0] wdata;
    logic                      re;
    logic [ADDR_W-1:0]         raddr;
    logic [shk_pkg::TAG_W-1:0] rdata;

    logic          r_out_valid, n_out_valid;
    shk_pkg::t_out r_out_data;

    shk_engine #(
        .LIST_DEPTH (LIST_DEPTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    shk_list_ram #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/shk_checker.sv =====
// Port-level checks for the shortcut key remapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module shk_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          i_in_ready,
    input wire shk_pkg::t_in  i_in_data,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire shk_pkg::t_out i_out_data
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output item changed while stalled");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Reset returns the engine to idle
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // One item in flight: the input is not ready in the cycle after an item is accepted
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is at work");

endmodule

bind shortcut_key_remapper_core shk_checker u_shk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire
